@@ rtl/battery_percent_estimator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Battery percent estimator assertion macros
// Shared assertion shorthands; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BATTERY_PERCENT_ESTIMATOR_TOP_DEFINES_SVH
`define BATTERY_PERCENT_ESTIMATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define BPE_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
// consequent holds in the same cycle as the antecedent
`define BPE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
// consequent holds in the cycle after the antecedent
`define BPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define BPE_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define BPE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BPE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/bpe_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery percent estimator package
// Widths, fixed-point constants and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package bpe_pkg;

   // field widths
   localparam int RAW_W       = 16;
   localparam int GAIN_W      = 16;
   localparam int GAIN_FRAC_W = 12;
   localparam int PCT_W       = 7;
   localparam int TENTHS_W    = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // polynomial datapath widths
   localparam int ACC_W      = 44;                 // Horner accumulator, Q16
   localparam int MUL_W      = ACC_W + RAW_W + 1;  // accumulator times millivolts
   localparam int PROD_W     = 56;                 // products that really occur fit here
   localparam int COEF_W     = 30;
   localparam int Q16_FRAC_W = 16;
   localparam int NUM_TERMS  = 3;
   localparam int TERM_W     = 2;

   // divide-by-1000 unit: 14-bit quotient digits, each an estimate step then a remainder step
   localparam int DIV_DIGIT_W = 14;
   localparam int DIV_DIGITS  = PROD_W / DIV_DIGIT_W;
   localparam int DIV_CYCLES  = 2 * DIV_DIGITS;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);
   localparam int REM_W       = 10;
   localparam int DIV_PART_W  = REM_W + DIV_DIGIT_W;   // remainder and next digit
   localparam logic [REM_W-1:0] DIVISOR = 10'd1000;
   // ceil(2^34 / 1000): exact floor quotient for every partial dividend below 2^24
   localparam int                     RECIP1000_W     = 25;
   localparam logic [RECIP1000_W-1:0] RECIP1000       = 25'd17179870;
   localparam int                     RECIP1000_SHIFT = 34;

   // cubic LiPo coefficients, Q16
   localparam logic signed [COEF_W-1:0] COEF_A = -30'sd9498722;
   localparam logic signed [COEF_W-1:0] COEF_B = 30'sd108518631;
   localparam logic signed [COEF_W-1:0] COEF_C = -30'sd403626525;
   localparam logic signed [COEF_W-1:0] COEF_D = 30'sd491606521;
   localparam logic signed [COEF_W-1:0] HORNER_COEF [NUM_TERMS] = '{COEF_B, COEF_C, COEF_D};

   localparam logic signed [MUL_W-1:0] DIV_ROUND    = MUL_W'(500);
   localparam logic signed [ACC_W-1:0] Q16_HALF     = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] PCT_FULL_Q16 = ACC_W'(100 * 65536);

   // percentages and smoothing
   localparam logic [PCT_W-1:0]    PCT_MAX        = 7'd100;
   localparam logic [PCT_W-1:0]    PCT_ZERO       = 7'd0;
   localparam int                  SUM_W          = 14;
   localparam logic [3:0]          EMA_KEEP       = 4'd9;
   localparam logic [3:0]          EMA_NEW        = 4'd10;
   localparam logic [6:0]          SEED_SCALE     = 7'd100;
   localparam int                  RECIP_W        = 13;
   localparam logic [RECIP_W-1:0]  RECIP10        = 13'd6554;  // ceil(2^16 / 10)
   localparam int                  RECIP_SHIFT    = 16;
   localparam logic [TENTHS_W-1:0] TENTHS_MAX     = 10'd1000;
   localparam logic [GAIN_W-1:0]   GAIN_RESET     = 16'd8192;

   // source modes
   localparam logic MODE_ADC   = 1'b0;
   localparam logic MODE_GAUGE = 1'b1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_MODE  = 1'b0,
      CSR_DIVIDER_GAIN = 1'b1
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic              take_req;
      logic              scale;
      logic              mul;
      logic              div_start;
      logic              acc_update;
      logic [TERM_W-1:0] coef_sel;
      logic              clamp;
      logic              gauge;
      logic              ema_sum;
      logic              ema_div;
      logic              load_rsp;
   } bpe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic source_mode;
      logic div_done;
   } bpe_status_type;

endpackage

@@ rtl/bpe_div1000.sv @@
// ----------------------------------------------------------------------------
// Floor divide by 1000
// Signed floor division by 1000 as long division in 14-bit digits. For each
// digit a reciprocal multiply first estimates it, then the remainder is
// formed. A negative numerator n is handled as ~(~n / 1000), which floors.
// ----------------------------------------------------------------------------
`include "battery_percent_estimator_top_defines.svh"

module bpe_div1000 import bpe_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [PROD_W-1:0] numer,
   output logic                     done,
   output logic signed [PROD_W-1:0] quot
);

   logic [DIV_CNT_W-1:0]               cnt_ff, cnt_in;
   logic                               done_ff, done_in;
   logic                               neg_ff;
   logic [PROD_W-1:0]                  work_ff;
   logic [REM_W-1:0]                   rem_ff;
   logic [DIV_DIGIT_W-1:0]             digit_ff;
   logic [DIV_PART_W-1:0]              partial;
   logic [DIV_PART_W+RECIP1000_W-1:0]  recip_prod;
   logic [DIV_PART_W-1:0]              digit_scaled;
   logic [DIV_PART_W-1:0]              rem_full;

   // partial dividend: running remainder followed by the next digit
   assign partial = {rem_ff, work_ff[PROD_W-1 -: DIV_DIGIT_W]};

   // estimate the digit; exact since the partial dividend stays below 1000 * 2^14
   assign recip_prod = partial * RECIP1000;

   // remainder left by the registered digit
   assign digit_scaled = DIV_PART_W'(digit_ff) * DIV_PART_W'(DIVISOR);
   assign rem_full     = partial - digit_scaled;

   // count steps and flag the last one
   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_CYCLES);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
      done_in = !start && (cnt_ff == DIV_CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // load the numerator, inverted if negative, on start; even counts estimate, odd counts shift the digit in
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= numer[PROD_W-1];
         work_ff <= numer[PROD_W-1] ? ~numer : numer;
         rem_ff  <= '0;
      end else if (cnt_ff != '0) begin
         if (!cnt_ff[0]) begin
            digit_ff <= recip_prod[RECIP1000_SHIFT +: DIV_DIGIT_W];
         end else begin
            rem_ff  <= rem_full[REM_W-1:0];
            work_ff <= {work_ff[PROD_W-DIV_DIGIT_W-1:0], digit_ff};
         end
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? $signed(~work_ff) : $signed(work_ff);

   `BPE_ASSERT_IMPL(a_div_start_when_idle, clock, reset, start, cnt_ff == '0)

endmodule

@@ rtl/bpe_datapath.sv @@
// ----------------------------------------------------------------------------
// Battery percent estimator datapath
// Configuration registers, divider scaling, Horner evaluation of the cubic,
// gauge word check, exponential smoothing and the result register.
// ----------------------------------------------------------------------------
`include "battery_percent_estimator_top_defines.svh"

module bpe_datapath import bpe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic [RAW_W-1:0]       req_raw_value,
   input  logic                   req_read_ok,
   input  bpe_cmd_type            cmd,
   output bpe_status_type         status,
   output logic [PCT_W-1:0]       rsp_percent_now,
   output logic [PCT_W-1:0]       rsp_percent_smoothed
);

   // configuration
   logic              mode_ff;
   logic [GAIN_W-1:0] gain_ff;

   // working registers
   logic [RAW_W-1:0]         raw_ff;
   logic                     ok_ff;
   logic [RAW_W-1:0]         mv_ff, mv_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [PCT_W-1:0]         now_ff, now_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [TENTHS_W-1:0]      smooth_ff, smooth_in;
   logic                     seeded_ff;
   logic [PCT_W-1:0]         last_good_ff, last_good_in;
   logic [PCT_W-1:0]         rsp_now_ff;
   logic [PCT_W-1:0]         rsp_smooth_ff, rsp_smooth_in;

   // intermediate values
   logic [RAW_W+GAIN_W-1:0]        scale_prod;
   logic [RAW_W+GAIN_W-GAIN_FRAC_W-1:0] scale_shift;
   logic signed [MUL_W-1:0]        mul_full, mul_round;
   logic signed [PROD_W-1:0]       div_quot;
   logic                           div_done;
   logic signed [ACC_W-1:0]        rounded;
   logic [PCT_W-1:0]               clamp_pct;
   logic                           gauge_good;
   logic [SUM_W+RECIP_W-1:0]       sum_recip;
   logic [TENTHS_W+RECIP_W-1:0]    out_recip;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ADC;
         gain_ff <= GAIN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SOURCE_MODE:  mode_ff <= csr_write_data[0];
            CSR_DIVIDER_GAIN: gain_ff <= csr_write_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // scale by the divider gain and saturate to 16 bits
   assign scale_prod  = raw_ff * gain_ff;
   assign scale_shift = scale_prod[RAW_W+GAIN_W-1:GAIN_FRAC_W];
   assign mv_in = (|scale_shift[RAW_W+GAIN_W-GAIN_FRAC_W-1:RAW_W]) ? '1
                                                                   : scale_shift[RAW_W-1:0];

   // Horner multiply with rounding offset ahead of the divide
   assign mul_full  = acc_ff * $signed({1'b0, mv_ff});
   assign mul_round = mul_full + DIV_ROUND;
   assign prod_in   = mul_round[PROD_W-1:0];

   bpe_div1000 u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (prod_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // seed the accumulator or add the next coefficient
   always_comb begin
      acc_in = acc_ff;
      if (cmd.scale) begin
         acc_in = ACC_W'(COEF_A);
      end else if (cmd.acc_update) begin
         acc_in = $signed(div_quot[ACC_W-1:0]) + ACC_W'(HORNER_COEF[cmd.coef_sel]);
      end
   end

   // clamp the Q16 result to 0..100 and round half up
   assign rounded   = acc_ff + Q16_HALF;
   assign clamp_pct = acc_ff[ACC_W-1]      ? PCT_ZERO :
                      (acc_ff > PCT_FULL_Q16) ? PCT_MAX  :
                      rounded[Q16_FRAC_W +: PCT_W];

   // gauge word: keep the last good value on a failed or out-of-range read
   assign gauge_good   = ok_ff && (raw_ff <= RAW_W'(PCT_MAX));
   assign last_good_in = (cmd.gauge && gauge_good) ? raw_ff[PCT_W-1:0] : last_good_ff;

   always_comb begin
      now_in = now_ff;
      if (cmd.clamp) begin
         now_in = clamp_pct;
      end else if (cmd.gauge) begin
         now_in = gauge_good ? raw_ff[PCT_W-1:0] : last_good_ff;
      end
   end

   // smoothing: tenths sum, then divide by ten through a reciprocal
   assign sum_in = seeded_ff ?
                   SUM_W'(smooth_ff) * SUM_W'(EMA_KEEP) + SUM_W'(now_ff) * SUM_W'(EMA_NEW) :
                   SUM_W'(now_ff) * SUM_W'(SEED_SCALE);
   assign sum_recip     = sum_ff * RECIP10;
   assign smooth_in     = sum_recip[RECIP_SHIFT +: TENTHS_W];
   assign out_recip     = smooth_ff * RECIP10;
   assign rsp_smooth_in = out_recip[RECIP_SHIFT +: PCT_W];

   // state that persists across items
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff    <= '0;
         seeded_ff    <= 1'b0;
         last_good_ff <= PCT_MAX;
      end else begin
         last_good_ff <= last_good_in;
         if (cmd.ema_div) begin
            smooth_ff <= smooth_in;
            seeded_ff <= 1'b1;
         end
      end
   end

   // hold payload registers
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         raw_ff <= req_raw_value;
         ok_ff  <= req_read_ok;
      end
      if (cmd.scale) begin
         mv_ff <= mv_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      now_ff <= now_in;
      if (cmd.ema_sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.load_rsp) begin
         rsp_now_ff    <= now_ff;
         rsp_smooth_ff <= rsp_smooth_in;
      end
   end

   assign status.source_mode = mode_ff;
   assign status.div_done    = div_done;

   assign rsp_percent_now      = rsp_now_ff;
   assign rsp_percent_smoothed = rsp_smooth_ff;

   `BPE_ASSERT_ALWAYS(a_smooth_in_range, clock, reset, smooth_ff <= TENTHS_MAX)
   `BPE_ASSERT_ALWAYS(a_last_good_in_range, clock, reset, last_good_ff <= PCT_MAX)

endmodule

@@ rtl/bpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Battery percent estimator controller
// Sequences one item through scaling, three Horner terms and clamping, or the
// gauge check, then smoothing and the result register; owns the handshakes.
// ----------------------------------------------------------------------------
`include "battery_percent_estimator_top_defines.svh"

module bpe_ctrl import bpe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  bpe_status_type status,
   output bpe_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_SCALE   = 10'b00_0000_0010,
      ST_MUL     = 10'b00_0000_0100,
      ST_DSTART  = 10'b00_0000_1000,
      ST_DWAIT   = 10'b00_0001_0000,
      ST_CLAMP   = 10'b00_0010_0000,
      ST_GAUGE   = 10'b00_0100_0000,
      ST_EMA_SUM = 10'b00_1000_0000,
      ST_EMA_DIV = 10'b01_0000_0000,
      ST_EMIT    = 10'b10_0000_0000
   } state_type;

   localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(NUM_TERMS - 1);

   state_type         state_ff, state_in;
   logic [TERM_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (status.source_mode == MODE_GAUGE) ? ST_GAUGE : ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_MUL;
         ST_MUL:    state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (status.div_done) begin
               state_in = (step_ff == LAST_TERM) ? ST_CLAMP : ST_MUL;
            end
         end
         ST_CLAMP:   state_in = ST_EMA_SUM;
         ST_GAUGE:   state_in = ST_EMA_SUM;
         ST_EMA_SUM: state_in = ST_EMA_DIV;
         ST_EMA_DIV: state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.take_req   = accept;
      cmd.scale      = (state_ff == ST_SCALE);
      cmd.mul        = (state_ff == ST_MUL);
      cmd.div_start  = (state_ff == ST_DSTART);
      cmd.acc_update = (state_ff == ST_DWAIT) && status.div_done;
      cmd.coef_sel   = step_ff;
      cmd.clamp      = (state_ff == ST_CLAMP);
      cmd.gauge      = (state_ff == ST_GAUGE);
      cmd.ema_sum    = (state_ff == ST_EMA_SUM);
      cmd.ema_div    = (state_ff == ST_EMA_DIV);
      cmd.load_rsp   = (state_ff == ST_EMIT) && slot_free;
   end

   // Horner term counter
   always_comb begin
      step_in = step_ff;
      if (cmd.scale) begin
         step_in = '0;
      end else if (cmd.acc_update) begin
         step_in = step_ff + TERM_W'(1);
      end
   end

   // result word valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BPE_ASSERT_IMPL(a_div_done_in_wait, clock, reset, status.div_done, state_ff == ST_DWAIT)
   `BPE_ASSERT_NEXT(a_accept_starts_work, clock, reset, accept, state_ff == ST_SCALE || state_ff == ST_GAUGE)

endmodule

@@ rtl/battery_percent_estimator_top.sv @@
// ----------------------------------------------------------------------------
// Battery percent estimator
// Each accepted word is one battery reading and yields one result word with
// the raw and the smoothed charge percentage. In ADC mode the reading is
// scaled by the Q4.12 divider gain and run through a cubic LiPo curve; in
// gauge mode it is a state-of-charge word, used if the read is good and at
// most 100, else the last good value stands. Items are handled one at a time;
// an item is held at the end while the previous result word is still unread.
// An ADC item passes through the shared divide-by-1000 unit, which forms a
// 56-bit quotient as four 14-bit digits, each by a reciprocal multiply, then
// the remainder, and runs once for each of the three Horner terms. A finished
// result waits in its own register, so the next item is taken while it is
// still unread. The user must write registers through the csr port only
// while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module battery_percent_estimator_top import bpe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [RAW_W-1:0]       req_raw_value,
   input  logic                   req_read_ok,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PCT_W-1:0]       rsp_percent_now,
   output logic [PCT_W-1:0]       rsp_percent_smoothed,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   bpe_cmd_type    cmd;
   bpe_status_type status;

   // sequence the item
   bpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // compute the percentages
   bpe_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_raw_value        (req_raw_value),
      .req_read_ok          (req_read_ok),
      .cmd                  (cmd),
      .status               (status),
      .rsp_percent_now      (rsp_percent_now),
      .rsp_percent_smoothed (rsp_percent_smoothed)
   );

endmodule
